>>> rtl/core/irr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package irr_pkg;

  localparam int MAX_SRC_WIDTH  = 512;
  localparam int MAX_SRC_HEIGHT = 512;
  localparam int FRAC_BITS      = 8;

  localparam int COS_W   = 15;
  localparam int SIN_W   = 16;
  localparam int SZ_W    = 10;
  localparam int RS_W    = 11;
  localparam int CRD_W   = 10;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS    = 3'd0,
    REG_SIN    = 3'd1,
    REG_SRC_W  = 3'd2,
    REG_SRC_H  = 3'd3,
    REG_RES_W  = 3'd4,
    REG_RES_H  = 3'd5,
    REG_MODE   = 3'd6
  } cfg_reg_e;

  // Coordinate mapping arithmetic, in units of 2^-15 pixel.
  localparam int DLT_W  = RS_W + 1;
  localparam int PROD_W = SIN_W + DLT_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int CTR_SH = 14;
  localparam int SHIFT  = 15 - FRAC_BITS;
  localparam int RND    = 1 << (14 - FRAC_BITS);
  localparam int PX_W   = SUM_W - SHIFT;
  localparam int POS_W  = PX_W - FRAC_BITS;
  localparam int HALF   = 1 << (FRAC_BITS - 1);

  // Blend arithmetic.
  localparam int ONE    = 1 << FRAC_BITS;
  localparam int FW1    = FRAC_BITS + 1;
  localparam int WGT_W  = 2 * FRAC_BITS + 1;
  localparam int PRD_W  = CH_W + WGT_W;
  localparam int ACC_W  = PRD_W + 2;

  // Frame store split into four banks by row and column parity.
  localparam int HALF_W     = (MAX_SRC_WIDTH + 1) / 2;
  localparam int HALF_H     = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int HX_W       = $clog2(HALF_W + 1);
  localparam int HY_W       = $clog2(HALF_H + 1);
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int NBANK      = 4;

  localparam int QDEPTH = 4;
  localparam int QA_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [COS_W-1:0]        cos_c;
    logic signed [SIN_W-1:0] sin_c;
    logic [SZ_W-1:0]         eff_w;
    logic [SZ_W-1:0]         eff_h;
    logic [RS_W-1:0]         res_w;
    logic [RS_W-1:0]         res_h;
    logic                    bilinear;
  } irr_cfg_t;

  typedef struct packed {
    logic                    is_read;
    logic                    wr_ok;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [FRAC_BITS-1:0]    frac_x;
    logic [FRAC_BITS-1:0]    frac_y;
    logic [PIX_W-1:0]        pixel;
  } irr_item_t;

endpackage
`default_nettype wire

>>> rtl/core/irr_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface irr_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [9:0] coord_x;
  logic [9:0] coord_y;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, req_type, coord_x, coord_y, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, req_type, coord_x, coord_y, red_in, green_in, blue_in,
                output ready);
endinterface

interface irr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       outside_source;

  modport source (output valid, red_out, green_out, blue_out, outside_source,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, outside_source,
                output ready);
endinterface
`default_nettype wire

>>> rtl/core/irr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module irr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          wr_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr_i,
  input  wire logic [WIDTH-1:0]                              wr_data_i,
  input  wire logic                                          rd_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr_i,
  output logic      [WIDTH-1:0]                              rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/irr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module irr_front
  import irr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  irr_req_if.sink       req_i,
  input  wire irr_cfg_t cfg_i,
  output irr_item_t     item_o,
  output logic          item_valid_o,
  input  wire logic     item_ready_i
);

  logic f_en;

  logic                    f1_v_q, f2_v_q, f3_v_q;
  logic                    f1_rd_q, f2_rd_q, f3_rd_q;
  logic                    f1_ok_q, f2_ok_q, f3_ok_q;
  logic [CRD_W-1:0]        f1_x_q, f2_x_q, f3_x_q;
  logic [CRD_W-1:0]        f1_y_q, f2_y_q, f3_y_q;
  logic [PIX_W-1:0]        f1_pix_q, f2_pix_q, f3_pix_q;
  logic signed [DLT_W-1:0] dx_d, dy_d, f1_dx_q, f1_dy_q;
  logic signed [COS_W:0]   cos_s;
  logic signed [PROD_W-1:0] pcx_d, psy_d, psx_d, pcy_d;
  logic signed [PROD_W-1:0] f2_pcx_q, f2_psy_q, f2_psx_q, f2_pcy_q;
  logic signed [SUM_W-1:0] ctr_x, ctr_y, vx, vy;
  logic signed [PX_W-1:0]  px_d, py_d, f3_px_q, f3_py_q, nx, ny;
  logic                    wr_ok_d;

  assign f_en        = !f3_v_q || item_ready_i;
  assign req_i.ready = f_en;

  assign dx_d    = $signed({1'b0, req_i.coord_x, 1'b0}) - $signed({1'b0, cfg_i.res_w});
  assign dy_d    = $signed({1'b0, req_i.coord_y, 1'b0}) - $signed({1'b0, cfg_i.res_h});
  assign wr_ok_d = (32'(req_i.coord_x) < MAX_SRC_WIDTH) &&
                   (32'(req_i.coord_y) < MAX_SRC_HEIGHT);

  assign cos_s = $signed({1'b0, cfg_i.cos_c});
  assign pcx_d = cos_s * f1_dx_q;
  assign psy_d = cfg_i.sin_c * f1_dy_q;
  assign psx_d = cfg_i.sin_c * f1_dx_q;
  assign pcy_d = cos_s * f1_dy_q;

  assign ctr_x = (SUM_W'($signed({1'b0, cfg_i.eff_w})) - SUM_W'(1)) <<< CTR_SH;
  assign ctr_y = (SUM_W'($signed({1'b0, cfg_i.eff_h})) - SUM_W'(1)) <<< CTR_SH;
  assign vx    = SUM_W'(f2_pcx_q) - SUM_W'(f2_psy_q) + ctr_x + SUM_W'(RND);
  assign vy    = SUM_W'(f2_psx_q) + SUM_W'(f2_pcy_q) + ctr_y + SUM_W'(RND);
  assign px_d  = $signed(vx[SUM_W-1:SHIFT]);
  assign py_d  = $signed(vy[SUM_W-1:SHIFT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
    end else if (f_en) begin
      f1_v_q <= req_i.valid;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_en) begin
      f1_rd_q  <= req_i.req_type;
      f1_ok_q  <= wr_ok_d;
      f1_x_q   <= req_i.coord_x;
      f1_y_q   <= req_i.coord_y;
      f1_pix_q <= {req_i.red_in, req_i.green_in, req_i.blue_in};
      f1_dx_q  <= dx_d;
      f1_dy_q  <= dy_d;
      f2_rd_q  <= f1_rd_q;
      f2_ok_q  <= f1_ok_q;
      f2_x_q   <= f1_x_q;
      f2_y_q   <= f1_y_q;
      f2_pix_q <= f1_pix_q;
      f2_pcx_q <= pcx_d;
      f2_psy_q <= psy_d;
      f2_psx_q <= psx_d;
      f2_pcy_q <= pcy_d;
      f3_rd_q  <= f2_rd_q;
      f3_ok_q  <= f2_ok_q;
      f3_x_q   <= f2_x_q;
      f3_y_q   <= f2_y_q;
      f3_pix_q <= f2_pix_q;
      f3_px_q  <= px_d;
      f3_py_q  <= py_d;
    end
  end

  // Nearest mode rounds half up and leaves no fraction, so the back end
  // puts the full weight on one neighbor.
  assign nx = f3_px_q + PX_W'(HALF);
  assign ny = f3_py_q + PX_W'(HALF);

  always_comb begin
    item_o.is_read = f3_rd_q;
    item_o.wr_ok   = f3_ok_q;
    item_o.pixel   = f3_pix_q;
    if (!f3_rd_q) begin
      item_o.pos_x  = POS_W'(f3_x_q);
      item_o.pos_y  = POS_W'(f3_y_q);
      item_o.frac_x = '0;
      item_o.frac_y = '0;
    end else if (cfg_i.bilinear) begin
      item_o.pos_x  = f3_px_q[PX_W-1:FRAC_BITS];
      item_o.pos_y  = f3_py_q[PX_W-1:FRAC_BITS];
      item_o.frac_x = f3_px_q[FRAC_BITS-1:0];
      item_o.frac_y = f3_py_q[FRAC_BITS-1:0];
    end else begin
      item_o.pos_x  = nx[PX_W-1:FRAC_BITS];
      item_o.pos_y  = ny[PX_W-1:FRAC_BITS];
      item_o.frac_x = '0;
      item_o.frac_y = '0;
    end
  end

  assign item_valid_o = f3_v_q;

endmodule
`default_nettype wire

>>> rtl/core/irr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module irr_queue
  import irr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire irr_item_t in_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output irr_item_t      out_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i
);

  irr_item_t       buf_q [QDEPTH];
  logic [QA_W-1:0] wp_q, rp_q;
  logic [QC_W-1:0] cnt_q;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != QC_W'(QDEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_o       = buf_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + QA_W'(1);
      end
      if (pop) begin
        rp_q <= rp_q + QA_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QC_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= in_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QC_W'(QDEPTH))
    else $error("queue fill count above depth");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + QC_W'(1))
    else $error("queue fill count did not follow a push");

endmodule
`default_nettype wire

>>> rtl/core/irr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module irr_back
  import irr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire irr_cfg_t  cfg_i,
  input  wire irr_item_t item_i,
  input  wire logic      item_valid_i,
  output logic           item_ready_o,
  irr_rsp_if.source      rsp_o
);

  logic en, pop, out_v_q;

  logic [BA_W-1:0]  addr   [NBANK];
  logic [BA_W-1:0]  rd_adr [NBANK];
  logic             ins    [NBANK];
  logic             cnt    [NBANK];
  logic             wr_en  [NBANK];
  logic [WGT_W-1:0] wgt    [NBANK];
  logic [PIX_W-1:0] rd_data[NBANK];

  logic             b1_v_q;
  logic             b1_ins_q [NBANK];
  logic             b1_cnt_q [NBANK];
  logic [WGT_W-1:0] b1_w_q   [NBANK];

  logic             b2_v_q;
  logic             b2_out_q;
  logic [PRD_W-1:0] b2_p_q [NBANK][3];

  logic [ACC_W-1:0] acc [3];
  logic [CH_W-1:0]  chv [3];
  logic [CH_W-1:0]  out_ch_q [3];
  logic             out_os_q;

  assign en           = !out_v_q || rsp_o.ready;
  assign pop          = en && item_valid_i;
  assign item_ready_o = en;

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    logic                  ox, oy;
    logic signed [POS_W:0] cx, cy;
    logic [HX_W-1:0]       hx;
    logic [HY_W-1:0]       hy;
    logic [FW1-1:0]        wx, wy;
    logic [CH_W-1:0]       pch [3];

    assign ox = 1'(b % 2) ^ item_i.pos_x[0];
    assign oy = 1'(b / 2) ^ item_i.pos_y[0];
    assign cx = (POS_W+1)'(item_i.pos_x) + (POS_W+1)'(ox);
    assign cy = (POS_W+1)'(item_i.pos_y) + (POS_W+1)'(oy);
    assign hx = cx[HX_W:1];
    assign hy = cy[HY_W:1];
    assign addr[b] = BA_W'(hy) * BA_W'(HALF_W) + BA_W'(hx);
    assign ins[b]  = !cx[POS_W] && !cy[POS_W] &&
                     ($unsigned(cx) < (POS_W+1)'(cfg_i.eff_w)) &&
                     ($unsigned(cy) < (POS_W+1)'(cfg_i.eff_h));
    assign cnt[b]  = ins[b] && (cfg_i.bilinear || (!ox && !oy));
    assign rd_adr[b] = ins[b] ? addr[b] : '0;
    assign wr_en[b]  = pop && !item_i.is_read && item_i.wr_ok && !ox && !oy;

    assign wx = ox ? {1'b0, item_i.frac_x} : FW1'(ONE) - {1'b0, item_i.frac_x};
    assign wy = oy ? {1'b0, item_i.frac_y} : FW1'(ONE) - {1'b0, item_i.frac_y};
    assign wgt[b] = wx * wy;

    irr_ram #(
      .WIDTH(PIX_W),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk_i    (clk_i),
      .wr_en_i  (wr_en[b]),
      .wr_addr_i(addr[b]),
      .wr_data_i(item_i.pixel),
      .rd_en_i  (pop && item_i.is_read),
      .rd_addr_i(rd_adr[b]),
      .rd_data_o(rd_data[b])
    );

    for (genvar c = 0; c < 3; c++) begin : g_ch
      assign pch[c] = b1_ins_q[b] ? rd_data[b][PIX_W-1-CH_W*c -: CH_W] : '0;
      always_ff @(posedge clk_i) begin
        if (en) begin
          b2_p_q[b][c] <= pch[c] * b1_w_q[b];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        b1_ins_q[b] <= ins[b];
        b1_cnt_q[b] <= cnt[b];
        b1_w_q[b]   <= wgt[b];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_sum
    assign acc[c] = ACC_W'(b2_p_q[0][c]) + ACC_W'(b2_p_q[1][c]) +
                    ACC_W'(b2_p_q[2][c]) + ACC_W'(b2_p_q[3][c]);
    assign chv[c] = (acc[c][ACC_W-1:2*FRAC_BITS] > (ACC_W-2*FRAC_BITS)'(255)) ?
                    CH_W'(255) : acc[c][2*FRAC_BITS +: CH_W];
    always_ff @(posedge clk_i) begin
      if (en) begin
        out_ch_q[c] <= chv[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      b1_v_q  <= pop && item_i.is_read;
      b2_v_q  <= b1_v_q;
      out_v_q <= b2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_out_q <= !(b1_cnt_q[0] || b1_cnt_q[1] || b1_cnt_q[2] || b1_cnt_q[3]);
      out_os_q <= b2_out_q;
    end
  end

  assign rsp_o.valid          = out_v_q;
  assign rsp_o.red_out        = out_ch_q[0];
  assign rsp_o.green_out      = out_ch_q[1];
  assign rsp_o.blue_out       = out_ch_q[2];
  assign rsp_o.outside_source = out_os_q;

  a_wr_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !item_i.is_read) |=> !b1_v_q)
    else $error("pixel write entered the blend pipeline");

  a_wgt_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b1_v_q |-> ((WGT_W+2)'(b1_w_q[0]) + (WGT_W+2)'(b1_w_q[1]) +
                (WGT_W+2)'(b1_w_q[2]) + (WGT_W+2)'(b1_w_q[3])) ==
               (WGT_W+2)'(ONE * ONE))
    else $error("blend weights do not sum to one");

endmodule
`default_nettype wire

>>> rtl/core/image_rotate_resample_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Rotating resampler over a 512 x 512 RGB frame store. Pixel writes and
// output pixel requests share one request channel and are served in order;
// each read request yields one response beat, a write yields none. The block
// takes one beat per clock and returns one pixel per clock in both nearest
// and bilinear mode unless the response side or a full queue stalls it, since
// the frame store is split into four banks by row and column parity so that
// all four neighbors are read in the same cycle. A request passes three front
// stages for the coordinate mapping, a four-entry queue, and three back stages
// for the bank read and the blend. Configuration must be written only while
// no request is in flight; the block itself does not enforce this.
module image_rotate_resample_top
  import irr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  irr_req_if.sink                    req_i,
  irr_rsp_if.source                  rsp_o
);

  logic [COS_W-1:0]        cos_q;
  logic signed [SIN_W-1:0] sin_q;
  logic [SZ_W-1:0]         src_w_q, src_h_q;
  logic [RS_W-1:0]         res_w_q, res_h_q;
  logic                    mode_q;
  irr_cfg_t                cfg;

  irr_item_t f_item, q_item;
  logic      f_valid, f_ready, q_valid, q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q   <= COS_W'(16384);
      sin_q   <= '0;
      src_w_q <= SZ_W'(512);
      src_h_q <= SZ_W'(512);
      res_w_q <= RS_W'(512);
      res_h_q <= RS_W'(512);
      mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_COS:   cos_q   <= cfg_wdata_i[COS_W-1:0];
        REG_SIN:   sin_q   <= $signed(cfg_wdata_i[SIN_W-1:0]);
        REG_SRC_W: src_w_q <= cfg_wdata_i[SZ_W-1:0];
        REG_SRC_H: src_h_q <= cfg_wdata_i[SZ_W-1:0];
        REG_RES_W: res_w_q <= cfg_wdata_i[RS_W-1:0];
        REG_RES_H: res_h_q <= cfg_wdata_i[RS_W-1:0];
        REG_MODE:  mode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.cos_c    = cos_q;
    cfg.sin_c    = sin_q;
    cfg.eff_w    = (32'(src_w_q) > MAX_SRC_WIDTH) ? SZ_W'(MAX_SRC_WIDTH) : src_w_q;
    cfg.eff_h    = (32'(src_h_q) > MAX_SRC_HEIGHT) ? SZ_W'(MAX_SRC_HEIGHT) : src_h_q;
    cfg.res_w    = res_w_q;
    cfg.res_h    = res_h_q;
    cfg.bilinear = mode_q;
  end

  irr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_i       (cfg),
    .item_o      (f_item),
    .item_valid_o(f_valid),
    .item_ready_i(f_ready)
  );

  irr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (f_item),
    .in_valid_i (f_valid),
    .in_ready_o (f_ready),
    .out_o      (q_item),
    .out_valid_o(q_valid),
    .out_ready_i(q_ready)
  );

  irr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_i      (q_item),
    .item_valid_i(q_valid),
    .item_ready_o(q_ready),
    .rsp_o       (rsp_o)
  );

endmodule
`default_nettype wire

>>> test/image_rotate_resample_top_tb.sv
`timescale 1ns / 1ps
module image_rotate_resample_top_tb;
  import irr_pkg::*;

  localparam bit REQ_WRITE = 1'b0;
  localparam bit REQ_READ  = 1'b1;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 24;

  typedef struct {
    bit       rd;
    bit [9:0] x;
    bit [9:0] y;
    bit [7:0] r;
    bit [7:0] g;
    bit [7:0] b;
  } pixel_req_t;

  typedef struct {
    bit [7:0] r;
    bit [7:0] g;
    bit [7:0] b;
    bit       outside;
  } pixel_rsp_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  irr_req_if req_if();
  irr_rsp_if rsp_if();

  image_rotate_resample_top DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i(req_if),
    .rsp_o(rsp_if)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  bit [COS_W-1:0] cos_c;
  bit signed [SIN_W-1:0] sin_c;
  bit [SZ_W-1:0] src_w;
  bit [SZ_W-1:0] src_h;
  bit [RS_W-1:0] res_w;
  bit [RS_W-1:0] res_h;
  bit bilinear;

  logic [PIX_W-1:0] frame_model [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
  bit written [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];

  pixel_req_t pending_reqs[$];
  pixel_rsp_t expected_pixels[$];
  pixel_req_t cur;
  int in_flight;
  int src_gap;
  int sink_gap;
  int errors;
  int idle_cycles;
  bit quiet;

  function automatic longint eff_w();
    return (src_w > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : src_w;
  endfunction

  function automatic longint eff_h();
    return (src_h > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : src_h;
  endfunction

  function automatic bit is_inside(longint x, longint y);
    return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
  endfunction

  function automatic longint map_axis(longint a, longint da, longint b, longint db,
                                      longint ctr);
    longint v;
    v = a * da + b * db + (ctr - 1) * 16384 + RND;
    return v >>> SHIFT;
  endfunction

  function automatic void source_pos(input bit [9:0] xo, input bit [9:0] yo,
                                     output longint px, output longint py);
    longint dx;
    longint dy;
    longint c;
    longint s;
    dx = 2 * longint'(xo) - longint'(res_w);
    dy = 2 * longint'(yo) - longint'(res_h);
    c = longint'(cos_c);
    s = longint'(sin_c);
    px = map_axis(c, dx, -s, dy, eff_w());
    py = map_axis(s, dx, c, dy, eff_h());
  endfunction

  function automatic bit fetch(longint x, longint y, output logic [PIX_W-1:0] pix);
    if (is_inside(x, y)) begin
      pix = frame_model[y * MAX_SRC_WIDTH + x];
      return 1'b1;
    end
    pix = '0;
    return 1'b0;
  endfunction

  function automatic void predict_pixel(pixel_req_t it);
    longint px;
    longint py;
    longint x0;
    longint y0;
    longint fx;
    longint fy;
    longint w [4];
    longint sum;
    longint v;
    logic [PIX_W-1:0] p [4];
    bit any_in;
    pixel_rsp_t rsp;
    if (it.rd == REQ_WRITE) begin
      if (it.x < MAX_SRC_WIDTH && it.y < MAX_SRC_HEIGHT)
        frame_model[it.y * MAX_SRC_WIDTH + it.x] = {it.r, it.g, it.b};
      return;
    end
    source_pos(it.x, it.y, px, py);
    if (!bilinear) begin
      any_in = fetch((px + HALF) >>> FRAC_BITS, (py + HALF) >>> FRAC_BITS, p[0]);
      {rsp.r, rsp.g, rsp.b} = p[0];
    end else begin
      x0 = px >>> FRAC_BITS;
      y0 = py >>> FRAC_BITS;
      fx = px - x0 * ONE;
      fy = py - y0 * ONE;
      any_in = fetch(x0, y0, p[0]);
      any_in |= fetch(x0 + 1, y0, p[1]);
      any_in |= fetch(x0, y0 + 1, p[2]);
      any_in |= fetch(x0 + 1, y0 + 1, p[3]);
      w[0] = (ONE - fx) * (ONE - fy);
      w[1] = fx * (ONE - fy);
      w[2] = (ONE - fx) * fy;
      w[3] = fx * fy;
      for (int k = 0; k < 3; k++) begin
        sum = 0;
        for (int j = 0; j < 4; j++)
          sum += longint'(p[j][16-8*k +: 8]) * w[j];
        v = sum >>> (2 * FRAC_BITS);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        case (k)
          0: rsp.r = v[7:0];
          1: rsp.g = v[7:0];
          default: rsp.b = v[7:0];
        endcase
      end
    end
    rsp.outside = !any_in;
    expected_pixels.push_back(rsp);
  endfunction

  task automatic push_req(bit rd, bit [9:0] x, bit [9:0] y, bit [23:0] rgb);
    pixel_req_t it;
    it.rd = rd;
    it.x = x;
    it.y = y;
    {it.r, it.g, it.b} = rgb;
    if (rd == REQ_WRITE && x < MAX_SRC_WIDTH && y < MAX_SRC_HEIGHT)
      written[y * MAX_SRC_WIDTH + x] = 1'b1;
    pending_reqs.push_back(it);
    in_flight++;
  endtask

  task automatic fill_neighbor(longint x, longint y);
    if (is_inside(x, y) && !written[y * MAX_SRC_WIDTH + x])
      push_req(REQ_WRITE, x[9:0], y[9:0], $urandom);
  endtask

  // Every neighbor the read will fetch gets written first.
  task automatic push_read(bit [9:0] x, bit [9:0] y);
    longint px;
    longint py;
    source_pos(x, y, px, py);
    if (!bilinear) begin
      fill_neighbor((px + HALF) >>> FRAC_BITS, (py + HALF) >>> FRAC_BITS);
    end else begin
      for (int j = 0; j < 4; j++)
        fill_neighbor((px >>> FRAC_BITS) + j % 2, (py >>> FRAC_BITS) + j / 2);
    end
    push_req(REQ_READ, x, y, $urandom);
  endtask

  task automatic wait_drained();
    wait (in_flight == 0 && expected_pixels.size() == 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, bit [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic configure(bit [COS_W-1:0] c, bit [SIN_W-1:0] s, bit [SZ_W-1:0] sw,
                           bit [SZ_W-1:0] sh, bit [RS_W-1:0] rw, bit [RS_W-1:0] rh,
                           bit m);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_reg(REG_COS, 16'(c));
    write_reg(REG_SIN, s);
    write_reg(REG_SRC_W, 16'(sw));
    write_reg(REG_SRC_H, 16'(sh));
    write_reg(REG_RES_W, 16'(rw));
    write_reg(REG_RES_H, 16'(rh));
    write_reg(REG_MODE, 16'(m));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cos_c = c;
    sin_c = s;
    src_w = sw;
    src_h = sh;
    res_w = rw;
    res_h = rh;
    bilinear = m;
  endtask

  task automatic random_phase(int n, bit hold_midway);
    int sel;
    int xmax;
    int ymax;
    for (int i = 0; i < n; i++) begin
      if (hold_midway && i == n / 2)
        wait_drained();
      sel = $urandom_range(0, 99);
      xmax = (res_w + 4 > 1023) ? 1023 : res_w + 4;
      ymax = (res_h + 4 > 1023) ? 1023 : res_h + 4;
      if (sel < 20 && eff_w() > 0 && eff_h() > 0)
        push_req(REQ_WRITE, $urandom_range(0, eff_w() - 1), $urandom_range(0, eff_h() - 1),
                 $urandom);
      else if (sel < 25)
        push_req(REQ_WRITE, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
      else if (sel < 35)
        push_read($urandom_range(0, 1023), $urandom_range(0, 1023));
      else
        push_read($urandom_range(0, xmax), $urandom_range(0, ymax));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_pixel(cur);
        in_flight--;
      end
      if (!req_if.valid || req_if.ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur = pending_reqs.pop_front();
          req_if.valid <= 1'b1;
          req_if.req_type <= cur.rd;
          req_if.coord_x <= cur.x;
          req_if.coord_y <= cur.y;
          req_if.red_in <= cur.r;
          req_if.green_in <= cur.g;
          req_if.blue_in <= cur.b;
          if (!quiet && $urandom_range(0, 11) == 0)
            src_gap <= $urandom_range(1, 16);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    pixel_rsp_t exp_px;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected beat: r=%0d g=%0d b=%0d outside=%0d", rsp_if.red_out,
                     rsp_if.green_out, rsp_if.blue_out, rsp_if.outside_source);
        end else begin
          exp_px = expected_pixels.pop_front();
          if (rsp_if.red_out !== exp_px.r || rsp_if.green_out !== exp_px.g ||
              rsp_if.blue_out !== exp_px.b || rsp_if.outside_source !== exp_px.outside) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected r=%0d g=%0d b=%0d outside=%0d, got r=%0d g=%0d b=%0d outside=%0d",
                       exp_px.r, exp_px.g, exp_px.b, exp_px.outside, rsp_if.red_out,
                       rsp_if.green_out, rsp_if.blue_out, rsp_if.outside_source);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        sink_gap <= $urandom_range(0, 15);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_WRITE;
    req_if.coord_x = '0;
    req_if.coord_y = '0;
    req_if.red_in = '0;
    req_if.green_in = '0;
    req_if.blue_in = '0;
    rsp_if.ready = 1'b0;
    in_flight = 0;
    src_gap = 0;
    sink_gap = 0;
    errors = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    cos_c = 16384;
    sin_c = 0;
    src_w = 512;
    src_h = 512;
    res_w = 512;
    res_h = 512;
    bilinear = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Small upright image in nearest mode, extreme samples and coordinates.
    configure(16384, 0, 4, 3, 4, 3, 1'b0);
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 4; x++)
        push_req(REQ_WRITE, x, y, ((x + y) % 2) ? 24'hffffff : 24'h000000);
    push_req(REQ_WRITE, 1023, 1023, 24'hffffff);
    push_req(REQ_WRITE, 600, 2, 24'h123456);
    push_read(0, 0);
    push_read(3, 2);
    push_read(1023, 1023);
    push_read(1023, 0);
    push_read(2, 1);

    // Quarter turn in bilinear mode, then negative sine with odd sizes.
    configure(0, 16384, 4, 3, 3, 4, 1'b1);
    push_read(0, 0);
    push_read(1, 2);
    push_read(2, 3);
    push_read(512, 512);
    configure(11585, -16'sd11585, 5, 5, 7, 7, 1'b1);
    push_read(3, 3);
    push_read(0, 6);
    push_read(6, 0);

    // Zero and oversized source sizes, extreme result sizes.
    configure(16384, 0, 0, 0, 0, 0, 1'b1);
    push_read(0, 0);
    push_read(1023, 1023);
    configure(32767, -16'sd16384, 1023, 1023, 2047, 2047, 1'b0);
    random_phase(60, 1'b0);
    configure(16384, 16384, 512, 512, 1024, 1024, 1'b1);
    random_phase(60, 1'b1);
    configure(0, -16'sd16384, 1, 1, 1, 1, 1'b0);
    random_phase(40, 1'b0);

    for (int p = 0; p < 10; p++) begin
      configure($urandom_range(0, 16384), 16'($signed($urandom_range(0, 32768)) - 16384),
                ($urandom_range(0, 7) == 0) ? 512 : $urandom_range(1, 24),
                ($urandom_range(0, 7) == 0) ? 512 : $urandom_range(1, 24),
                $urandom_range(1, ($urandom_range(0, 5) == 0) ? 1024 : 40),
                $urandom_range(1, ($urandom_range(0, 5) == 0) ? 1024 : 40),
                $urandom_range(0, 1));
      if (p == 9)
        quiet = 1'b1;
      random_phase(110, p == 4);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
